>>> design/sunday_pattern_search_top_macros.svh
// ---------------------------------------------------------------------------
// Sunday pattern search: assertion macros
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SUNDAY_PATTERN_SEARCH_TOP_MACROS_SVH
`define SUNDAY_PATTERN_SEARCH_TOP_MACROS_SVH

// Same-cycle implication
`define SPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sps_pkg.sv
// ---------------------------------------------------------------------------
// Sunday pattern search package
// Command codes, result status codes and fixed field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  // Item kind carried on the input tuser
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_SOURCE  = 1'b1;

  // Fixed field widths
  localparam int STATUS_W   = 3;
  localparam int OFFSET_W   = 12;
  localparam int SHIFT_W    = 7;
  localparam int BYTE_W     = 8;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = STATUS_W + 1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_SHORT     = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

endpackage

`default_nettype wire

>>> design/sunday_pattern_search_top.sv
// A pattern or source byte without last is taken and leaves the input ready.
// A last pattern byte starts a table rebuild, S_BUILD_RD then S_BUILD_WR per byte.
// A last source byte starts the search: S_CMP_RD, S_CMP per compared byte and
// S_SH_RD, S_SH_TAB, S_SH_ADD, S_CHK per window shift on the single source read
// port, then S_EMIT registers the result. Overflow, empty and short skip to S_EMIT.
// Reset (rst_n low, synchronous) empties pattern and source and sets all shifts to one.
`default_nettype none

`include "sunday_pattern_search_top_macros.svh"

// ---------------------------------------------------------------------------
// Sunday pattern search top level
// Loads pattern and source bytes, rebuilds the bad-character shift table and
// walks the source buffer with one shared compare and shift unit.
// ---------------------------------------------------------------------------
module sunday_pattern_search_top #(
  parameter int MAX_PATTERN = 64,
  parameter int MAX_SOURCE  = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input item
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]                     in_tuser,   // [0] cmd
  input  wire logic                           in_tlast,   // last
  // result item
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [sps_pkg::OUT_DATA_W-1:0]      out_tdata,  // [11:0] match_offset
  output logic [sps_pkg::OUT_USER_W-1:0]      out_tuser   // [2:0] status, [3] found
);
  import sps_pkg::*;

  localparam int AW  = $clog2(MAX_SOURCE);
  localparam int LW  = $clog2(MAX_SOURCE + 1);
  localparam int IW  = $clog2(MAX_SOURCE + 2 * MAX_PATTERN + 2);
  localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PLW = $clog2(MAX_PATTERN + 1);
  localparam int TAB_DEPTH = 256;

  localparam logic [PLW-1:0] MAXP = PLW'(MAX_PATTERN);
  localparam logic [LW-1:0]  MAXS = LW'(MAX_SOURCE);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUILD_RD,
    S_BUILD_WR,
    S_CMP_RD,
    S_CMP,
    S_SH_RD,
    S_SH_TAB,
    S_SH_ADD,
    S_CHK,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic [PLW-1:0]       plen_r;
  logic                 pcomplete_r;
  logic                 overflow_r;
  logic                 pover_r;
  logic [LW-1:0]        slen_r;
  logic [LW-1:0]        n_r;
  logic [IW-1:0]        i_r;
  logic [PLW-1:0]       j_r;
  logic [PLW-1:0]       k_r;
  logic [SHIFT_W-1:0]   default_r;
  status_t              res_status_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic                 out_found_r;
  logic [OFFSET_W-1:0]  out_offset_r;

  // storage
  logic [BYTE_W-1:0]    pat_mem [MAX_PATTERN];
  logic [BYTE_W-1:0]    src_mem [MAX_SOURCE];
  logic [SHIFT_W-1:0]   tab_mem [TAB_DEPTH];
  logic [TAB_DEPTH-1:0] tvld_r;
  logic [BYTE_W-1:0]    pat_q;
  logic [BYTE_W-1:0]    src_q;
  logic [SHIFT_W-1:0]   tab_q;
  logic                 hit_q;

  logic                 in_acc;
  logic                 is_pat;
  logic [PLW-1:0]       plen_base;
  logic                 pat_room;
  logic [PLW-1:0]       plen_nxt;
  logic                 src_room;
  logic [LW-1:0]        slen_nxt;
  logic                 ovf_src;
  logic [IW-1:0]        src_raddr;
  logic [PLW-1:0]       pat_raddr;
  logic [IW-1:0]        win_end;
  logic [SHIFT_W-1:0]   shift_amt;
  logic                 tab_clear;
  logic                 tab_wr;
  logic [OFFSET_W+IW-1:0] off_ext;

  // Input handshake and load bookkeeping
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_pat    = (in_tuser[0] == CMD_PATTERN);

  assign plen_base = pcomplete_r ? '0 : plen_r;
  assign pat_room  = (plen_base < MAXP);
  assign plen_nxt  = pat_room ? plen_base + 1'b1 : plen_base;
  assign src_room  = (slen_r < MAXS);
  assign slen_nxt  = src_room ? slen_r + 1'b1 : slen_r;
  assign ovf_src   = overflow_r || !src_room;

  // Shared address and shift selection
  assign win_end   = i_r + IW'(plen_r);
  assign src_raddr = (state_r == S_SH_RD) ? win_end : i_r + IW'(j_r);
  assign pat_raddr = (state_r == S_BUILD_RD) ? k_r : j_r;
  assign shift_amt = hit_q ? tab_q : default_r;
  assign off_ext   = {{OFFSET_W{1'b0}}, i_r};

  assign tab_clear = in_acc && is_pat && in_tlast;
  assign tab_wr    = (state_r == S_BUILD_WR);

  // Pattern and source buffers
  always_ff @(posedge clk) begin
    if (in_acc && is_pat && pat_room) begin
      pat_mem[plen_base[PAW-1:0]] <= in_tdata;
    end
    pat_q <= pat_mem[pat_raddr[PAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_pat && src_room) begin
      src_mem[slen_r[AW-1:0]] <= in_tdata;
    end
    src_q <= src_mem[src_raddr[AW-1:0]];
  end

  // Shift table, read at the byte just past the window
  always_ff @(posedge clk) begin
    if (tab_wr) begin
      tab_mem[pat_q] <= SHIFT_W'(plen_r - k_r);
    end
    tab_q <= tab_mem[src_q];
    hit_q <= tvld_r[src_q];
  end

  // Entry valid bits: an entry not rebuilt reads as the default shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvld_r <= '0;
    end else if (tab_clear) begin
      tvld_r <= '0;
    end else if (tab_wr) begin
      tvld_r[pat_q] <= 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      plen_r       <= '0;
      pcomplete_r  <= 1'b0;
      overflow_r   <= 1'b0;
      pover_r      <= 1'b0;
      slen_r       <= '0;
      n_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      default_r    <= SHIFT_W'(1);
      res_status_r <= ST_FOUND;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_FOUND;
      out_found_r  <= 1'b0;
      out_offset_r <= '0;
    end else begin
      // drop the result once taken
      if (out_valid_r && out_tready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && is_pat) begin
            plen_r      <= plen_nxt;
            pcomplete_r <= in_tlast;
            if (pcomplete_r) begin
              overflow_r <= 1'b0;
              pover_r    <= 1'b0;
            end
            if (!pat_room) begin
              overflow_r <= 1'b1;
              pover_r    <= 1'b1;
            end
            if (in_tlast) begin
              default_r <= SHIFT_W'(plen_nxt) + 1'b1;
              k_r       <= '0;
              state_r   <= S_BUILD_RD;
            end
          end else if (in_acc) begin
            if (!in_tlast) begin
              slen_r <= slen_nxt;
              if (!src_room) begin
                overflow_r <= 1'b1;
              end
            end else begin
              slen_r     <= '0;
              n_r        <= slen_nxt;
              overflow_r <= pover_r;
              i_r        <= '0;
              j_r        <= '0;
              priority if (ovf_src) begin
                res_status_r <= ST_OVERFLOW;
                state_r      <= S_EMIT;
              end else if (!pcomplete_r || plen_r == '0) begin
                res_status_r <= ST_EMPTY;
                state_r      <= S_EMIT;
              end else if (slen_nxt < LW'(plen_r)) begin
                res_status_r <= ST_SHORT;
                state_r      <= S_EMIT;
              end else begin
                state_r <= S_CMP_RD;
              end
            end
          end
        end

        // one pattern byte per pass into the table
        S_BUILD_RD: begin
          state_r <= S_BUILD_WR;
        end

        S_BUILD_WR: begin
          k_r <= k_r + 1'b1;
          if (k_r + 1'b1 == plen_r) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_BUILD_RD;
          end
        end

        S_CMP_RD: begin
          state_r <= S_CMP;
        end

        // compare one byte of the window
        S_CMP: begin
          if (src_q == pat_q) begin
            if (j_r + 1'b1 == plen_r) begin
              res_status_r <= ST_FOUND;
              state_r      <= S_EMIT;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_CMP_RD;
            end
          end else if (win_end >= IW'(n_r)) begin
            res_status_r <= ST_NOT_FOUND;
            state_r      <= S_EMIT;
          end else begin
            state_r <= S_SH_RD;
          end
        end

        S_SH_RD: begin
          state_r <= S_SH_TAB;
        end

        S_SH_TAB: begin
          state_r <= S_SH_ADD;
        end

        // advance the window by the table shift
        S_SH_ADD: begin
          i_r     <= i_r + IW'(shift_amt);
          j_r     <= '0;
          state_r <= S_CHK;
        end

        S_CHK: begin
          if (win_end <= IW'(n_r)) begin
            state_r <= S_CMP_RD;
          end else begin
            res_status_r <= ST_NOT_FOUND;
            state_r      <= S_EMIT;
          end
        end

        // hold until the output register is free
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_found_r  <= (res_status_r == ST_FOUND);
            out_offset_r <= (res_status_r == ST_FOUND) ? off_ext[OFFSET_W-1:0] : '0;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OFFSET_W){1'b0}}, out_offset_r};
  assign out_tuser  = {out_found_r, out_status_r};

  // Checks
  `SPS_ASSERT_NXT(a_busy_after_src_last,
    in_tvalid && in_tready && in_tuser[0] == CMD_SOURCE && in_tlast, !in_tready,
    "input still ready after last source byte")
  `SPS_ASSERT_IMP(a_offset_zero_unless_found,
    out_tvalid && !out_tuser[OUT_USER_W-1], out_tdata == '0,
    "non-zero offset without a match")
  `SPS_ASSERT_IMP(a_search_needs_pattern,
    state_r == S_CMP_RD, pcomplete_r && !overflow_r && plen_r != '0,
    "search running without a valid pattern")

endmodule

`default_nettype wire

>>> tb/sv/sps_search_checker.sv
`timescale 1ns / 100ps

// ---------------------------------------------------------------------------
// Sunday pattern search result checker
// Watches the item and result streams, keeps its own copy of the pattern,
// shift table and source buffer, predicts the outcome of every search and
// compares each delivered result with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module sps_search_checker #(
  parameter int MAX_PATTERN = 64,
  parameter int MAX_SOURCE  = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic [0:0]                        in_tuser,   // [0] cmd
  input  logic                              in_tlast,   // last
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [sps_pkg::OUT_DATA_W-1:0]    out_tdata,  // [11:0] match_offset
  input  logic [sps_pkg::OUT_USER_W-1:0]    out_tuser,  // [2:0] status, [3] found
  output int                                outstanding,
  output int                                fail_count
);
  import sps_pkg::*;

  typedef struct packed {
    status_t               status;
    logic                  found;
    logic [OFFSET_W-1:0]   offset;
  } search_result_t;

  // Predicted state of the block
  logic [BYTE_W-1:0]  pat_mem [MAX_PATTERN];
  logic [BYTE_W-1:0]  src_mem [MAX_SOURCE];
  logic [SHIFT_W-1:0] skip_tab [256];
  int unsigned        pat_len;
  int unsigned        src_len;
  bit                 pat_done;
  bit                 pat_lost;
  bit                 cap_flag;

  search_result_t     expected_results [$];

  initial begin
    outstanding = 0;
    fail_count  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] sps mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void clear_state();
    pat_len  = 0;
    src_len  = 0;
    pat_done = 1'b0;
    pat_lost = 1'b0;
    cap_flag = 1'b0;
    for (int k = 0; k < 256; k++) skip_tab[k] = SHIFT_W'(1);
    expected_results.delete();
  endfunction

  // Every byte gets length+1, pattern bytes get length minus their rightmost index
  function automatic void rebuild_skip_table();
    for (int k = 0; k < 256; k++) skip_tab[k] = SHIFT_W'(pat_len + 1);
    for (int unsigned k = 0; k < pat_len; k++) skip_tab[pat_mem[k]] = SHIFT_W'(pat_len - k);
  endfunction

  // Walk the buffered source with the bad-character shift
  function automatic status_t search_source(output logic [OFFSET_W-1:0] hit_at);
    int unsigned pos;
    int unsigned k;
    hit_at = '0;
    if (cap_flag) return ST_OVERFLOW;
    if (!pat_done || pat_len == 0) return ST_EMPTY;
    if (src_len < pat_len) return ST_SHORT;
    pos = 0;
    while (pos <= src_len - pat_len) begin
      k = 0;
      while (k < pat_len && src_mem[pos + k] == pat_mem[k]) k++;
      if (k == pat_len) begin
        hit_at = OFFSET_W'(pos);
        return ST_FOUND;
      end
      if (pos + pat_len >= src_len) break;
      pos += skip_tab[src_mem[pos + pat_len]];
    end
    return ST_NOT_FOUND;
  endfunction

  // Apply one accepted item and queue the result it causes, if any
  function automatic void absorb_item(input logic cmd, input logic [BYTE_W-1:0] value,
                                      input logic last_flag);
    search_result_t      res;
    logic [OFFSET_W-1:0] hit_at;
    if (cmd == CMD_PATTERN) begin
      // a pattern byte after a complete pattern starts a fresh one
      if (pat_done) begin
        pat_len  = 0;
        pat_done = 1'b0;
        cap_flag = 1'b0;
        pat_lost = 1'b0;
      end
      if (pat_len < MAX_PATTERN) begin
        pat_mem[pat_len] = value;
        pat_len++;
      end else begin
        cap_flag = 1'b1;
        pat_lost = 1'b1;
      end
      if (last_flag) begin
        pat_done = 1'b1;
        rebuild_skip_table();
      end
    end else begin
      if (src_len < MAX_SOURCE) begin
        src_mem[src_len] = value;
        src_len++;
      end else begin
        cap_flag = 1'b1;
      end
      if (last_flag) begin
        res.status = search_source(hit_at);
        res.found  = (res.status == ST_FOUND);
        res.offset = hit_at;
        expected_results.push_back(res);
        src_len = 0;
        // a lost pattern byte keeps the overflow until a new pattern starts
        if (!pat_lost) cap_flag = 1'b0;
      end
    end
  endfunction

  // Check results first: none can belong to an item taken at the same edge
  always @(posedge clk) begin
    search_result_t want;
    if (!rst_n) begin
      clear_state();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none outstanding: status %0d offset %0d",
                                    out_tuser[STATUS_W-1:0], out_tdata[OFFSET_W-1:0]));
        end else begin
          want = expected_results.pop_front();
          if (out_tuser[STATUS_W-1:0] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_tuser[STATUS_W-1:0], want.status));
          if (out_tuser[STATUS_W] !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b",
                                      out_tuser[STATUS_W], want.found));
          if (out_tdata[OFFSET_W-1:0] !== want.offset)
            report_mismatch($sformatf("match_offset %0d, expected %0d",
                                      out_tdata[OFFSET_W-1:0], want.offset));
        end
      end
      if (in_tvalid && in_tready) absorb_item(in_tuser[0], in_tdata, in_tlast);
    end
    outstanding <= expected_results.size();
  end

endmodule

>>> tb/sv/tb_sunday_pattern_search_top.sv
`timescale 1ns / 100ps

// ---------------------------------------------------------------------------
// Sunday pattern search testbench
// Drives pattern and source bytes with random gaps and result back-pressure,
// covering empty, short, not-found, found and capacity cases, then a long
// random run of pattern loads and searches; a separate checker predicts and
// compares every result.
// ---------------------------------------------------------------------------
module tb_sunday_pattern_search_top;
  import sps_pkg::*;

  localparam int MAX_PATTERN = 64;
  localparam int MAX_SOURCE  = 4096;
  localparam int ITEM_GOAL   = 420;
  localparam int SEARCH_GOAL = 25;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef logic [7:0] byte_q_t [$];

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [7:0]                 in_tdata   = '0;
  logic [0:0]                 in_tuser   = CMD_PATTERN;
  logic                       in_tlast   = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]      out_tdata;
  logic [OUT_USER_W-1:0]      out_tuser;

  int                         outstanding;
  int                         fail_count;
  int                         cycle_count  = 0;
  int                         items_sent   = 0;
  int                         searches     = 0;
  bit                         calm         = 1'b0;
  logic [7:0]                 alpha_base   = 8'h41;

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sunday_pattern_search_top #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_SOURCE  (MAX_SOURCE)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sps_search_checker #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_SOURCE  (MAX_SOURCE)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // Result back-pressure, held off entirely during the calm stretch
  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 17);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sunday_pattern_search_top test failed");
      $finish;
    end
  end

  // Offer one item after a random idle spell and hold it until taken
  task automatic send_item(input logic cmd, input logic [7:0] value, input logic last_flag);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    in_tlast  <= last_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_SOURCE && last_flag) searches++;
  endtask

  // Send a pattern or source run with last on its final byte
  task automatic send_run(input logic cmd, input byte_q_t bytes);
    foreach (bytes[k]) send_item(cmd, bytes[k], k == bytes.size() - 1);
  endtask

  // Hold the sender until every result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly a narrow alphabet so that partial and full matches are common
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 99) < 85) return alpha_base + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    byte_q_t     pat;
    byte_q_t     src;
    int          rand_start;
    int          search_start;
    int          len;
    int          off;
    int          pick;
    bit          drained;

    // Reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Search before any pattern: empty pattern
    send_item(CMD_SOURCE, 8'h00, 1'b1);
    // Source byte slipped into a pattern load, then found at offset one
    send_item(CMD_PATTERN, 8'h41, 1'b0);
    send_item(CMD_SOURCE,  8'h78, 1'b0);
    send_item(CMD_PATTERN, 8'h42, 1'b1);
    send_run(CMD_SOURCE, '{8'h41, 8'h42});
    // Source shorter than pattern
    send_item(CMD_SOURCE, 8'h41, 1'b1);
    // Source without a match: the last shift carries the window past the end
    send_run(CMD_SOURCE, '{8'h78, 8'h79, 8'h41, 8'h41, 8'h43});
    // Extreme byte values in pattern and source
    send_run(CMD_PATTERN, '{8'hFF, 8'h00});
    send_run(CMD_SOURCE, '{8'h00, 8'hFF, 8'h00});
    // Repeated byte: rightmost index sets the shift
    send_run(CMD_PATTERN, '{8'h61, 8'h62, 8'h61});
    send_run(CMD_SOURCE, '{8'h61, 8'h62, 8'h62, 8'h61, 8'h62, 8'h61});
    // Search against a pattern still loading: empty pattern
    send_item(CMD_PATTERN, 8'h55, 1'b0);
    send_item(CMD_SOURCE,  8'h55, 1'b1);
    send_item(CMD_PATTERN, 8'hAA, 1'b1);
    send_run(CMD_SOURCE, '{8'h55, 8'hAA});
    drain_results();

    // Pattern too long, last on a dropped byte: overflow until a new pattern
    pat.delete();
    for (int k = 0; k < MAX_PATTERN + 1; k++) pat.push_back(8'($urandom_range(0, 255)));
    send_run(CMD_PATTERN, pat);
    send_run(CMD_SOURCE, '{8'h61});
    send_run(CMD_SOURCE, pat);
    // Longest pattern, found at a small offset
    void'(pat.pop_back());
    send_run(CMD_PATTERN, pat);
    src = '{8'h01, 8'h02, 8'h03};
    foreach (pat[k]) src.push_back(pat[k]);
    send_run(CMD_SOURCE, src);
    drain_results();

    // Random pattern loads, searches and noise
    rand_start   = items_sent;
    search_start = searches;
    drained      = 1'b0;
    pat.delete();
    while (items_sent - rand_start < ITEM_GOAL || searches - search_start < SEARCH_GOAL) begin
      calm <= (items_sent - rand_start >= 150) && (items_sent - rand_start < 300);
      if (!drained && items_sent - rand_start >= 220) begin
        drain_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // new pattern, mostly short, sometimes long or overlong
        alpha_base = 8'($urandom_range(0, 255));
        off = $urandom_range(0, 99);
        len = (off < 3) ? $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6) :
              (off < 8) ? $urandom_range(7, MAX_PATTERN) : $urandom_range(1, 6);
        pat.delete();
        for (int k = 0; k < len; k++) pat.push_back(pick_byte());
        foreach (pat[k]) begin
          send_item(CMD_PATTERN, pat[k], k == len - 1);
          if (k < len - 1 && $urandom_range(0, 99) < 4)
            send_item(CMD_SOURCE, pick_byte(), 1'b0);
        end
      end else if (pick < 88) begin
        // source run, often carrying the pattern somewhere inside
        if (pat.size() == 0) len = $urandom_range(1, 20);
        else if ($urandom_range(0, 99) < 10) len = $urandom_range(1, 3);
        else len = pat.size() + $urandom_range(0, 24);
        src.delete();
        for (int k = 0; k < len; k++) src.push_back(pick_byte());
        if (pat.size() != 0 && len >= pat.size() && $urandom_range(0, 1)) begin
          off = $urandom_range(0, len - pat.size());
          foreach (pat[k]) src[off + k] = pat[k];
        end
        send_run(CMD_SOURCE, src);
      end else begin
        // stray item of any kind
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
    end
    calm <= 1'b0;

    // Wait for the tail, then the verdict
    drain_results();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("sunday_pattern_search_top test passed");
    end else begin
      $display("sunday_pattern_search_top test failed");
    end
    $finish;
  end

endmodule
